FILE: rtl/cha_pkg.sv
// ----------------------------------------------------------------------------
// cha_pkg
// Shared types and constants for the contiguous hole allocator.
// ----------------------------------------------------------------------------
package cha_pkg;

  localparam int MaxBlocks = 16;
  localparam int IdW       = 8;
  localparam int AddrW     = 16;
  localparam int PosW      = $clog2(MaxBlocks);
  localparam int CntW      = $clog2(MaxBlocks + 1);
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CfgMemSize = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFitMode = CfgIdxW'(1);
  localparam logic [AddrW-1:0]   MemSizeRst = AddrW'(1024);

  typedef enum logic [1:0] {
    FnAlloc   = 2'd0,
    FnFree    = 2'd1,
    FnCompact = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StTooBig   = 3'd1,
    StDupId    = 3'd2,
    StNoFit    = 3'd3,
    StNotFound = 3'd4,
    StFull     = 3'd5
  } status_e;

  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } stat_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
  } ent_t;

endpackage

FILE: rtl/cha_ctrl.sv
// ----------------------------------------------------------------------------
// cha_ctrl
// Sequencer: accept, scan the table one entry per cycle, commit and respond.
// ----------------------------------------------------------------------------
module cha_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cha_pkg::stat_t stat_i,
  output cha_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    SIdle   = 3'b001,
    SScan   = 3'b010,
    SCommit = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = SScan;
        end
      end
      SScan: begin
        cmd_o.step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = SCommit;
        end
      end
      SCommit: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          ovalid_d     = 1'b1;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = ovalid_q;

endmodule

FILE: rtl/cha_dp.sv
// ----------------------------------------------------------------------------
// cha_dp
// Block table, hole search, id match, compaction and result registers.
// ----------------------------------------------------------------------------
module cha_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cha_pkg::cmd_t                 cmd_i,
  output cha_pkg::stat_t                stat_o,
  input  logic                          cfg_we_i,
  input  logic [cha_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cha_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [1:0]                    func_i,
  input  logic [cha_pkg::IdW-1:0]       block_id_i,
  input  logic [cha_pkg::AddrW-1:0]     block_size_i,
  output logic [2:0]                    status_o,
  output logic [cha_pkg::AddrW-1:0]     start_address_o,
  output logic [cha_pkg::AddrW-1:0]     end_address_o,
  output logic [cha_pkg::AddrW-1:0]     free_remaining_o
);

  localparam int AW = cha_pkg::AddrW;
  localparam int CW = cha_pkg::CntW;
  localparam int PW = cha_pkg::PosW;
  localparam int NB = cha_pkg::MaxBlocks;

  cha_pkg::ent_t        ent_q [NB];
  logic [CW-1:0]        cnt_q, idx_q, best_pos_q, mpos_q;
  logic [AW-1:0]        mem_q, free_q;
  logic                 fit_q;
  logic [1:0]           func_q;
  logic [cha_pkg::IdW-1:0] id_q;
  logic [AW-1:0]        size_q, prev_q, top_q, best_len_q, best_lo_q, mlen_q, mhi_q;
  logic                 found_q, match_q;
  logic [2:0]           st_q;
  logic [AW-1:0]        sa_q, ea_q;

  cha_pkg::ent_t e;
  logic          in_tab, take, hit;
  logic [AW-1:0] he, hlen, elen;
  logic [2:0]    res_st;
  logic          do_ins, do_rem;

  assign e      = ent_q[idx_q[PW-1:0]];
  assign in_tab = idx_q < cnt_q;
  assign he     = in_tab ? e.lo : mem_q;
  assign hlen   = (he >= prev_q) ? he - prev_q : '0;
  assign elen   = e.hi - e.lo;
  assign take   = (func_q == cha_pkg::FnAlloc) && (size_q <= hlen)
                  && (!found_q || (fit_q && hlen < best_len_q));
  assign hit    = in_tab && !match_q && (e.id == id_q);
  assign stat_o.scan_last = (idx_q == cnt_q);

  always_comb begin
    res_st = cha_pkg::StOk;
    do_ins = 1'b0;
    do_rem = 1'b0;
    case (func_q)
      cha_pkg::FnAlloc: begin
        if (size_q > free_q)             res_st = cha_pkg::StTooBig;
        else if (match_q)                res_st = cha_pkg::StDupId;
        else if (cnt_q == CW'(NB))       res_st = cha_pkg::StFull;
        else if (!found_q)               res_st = cha_pkg::StNoFit;
        else                             do_ins = 1'b1;
      end
      cha_pkg::FnFree: begin
        if (!match_q) res_st = cha_pkg::StNotFound;
        else          do_rem = 1'b1;
      end
      default: res_st = cha_pkg::StOk;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mem_q  <= cha_pkg::MemSizeRst;
      free_q <= cha_pkg::MemSizeRst;
      fit_q  <= 1'b0;
    end else if (cfg_we_i && cfg_index_i == cha_pkg::CfgMemSize) begin
      mem_q  <= cfg_data_i[AW-1:0];
      free_q <= cfg_data_i[AW-1:0];
      cnt_q  <= '0;
    end else if (cfg_we_i && cfg_index_i == cha_pkg::CfgFitMode) begin
      fit_q <= cfg_data_i[0];
    end else if (cmd_i.commit) begin
      if (do_ins) begin
        cnt_q  <= cnt_q + CW'(1);
        free_q <= free_q - size_q;
      end else if (do_rem) begin
        cnt_q  <= cnt_q - CW'(1);
        free_q <= free_q + mlen_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q     <= func_i;
      id_q       <= block_id_i;
      size_q     <= block_size_i;
      idx_q      <= '0;
      prev_q     <= '0;
      top_q      <= '0;
      found_q    <= 1'b0;
      match_q    <= 1'b0;
      best_pos_q <= '0;
      best_len_q <= '0;
      best_lo_q  <= '0;
      mpos_q     <= '0;
      mlen_q     <= '0;
      mhi_q      <= '0;
    end
    if (cmd_i.step) begin
      idx_q <= idx_q + CW'(1);
      if (take) begin
        found_q    <= 1'b1;
        best_pos_q <= idx_q;
        best_len_q <= hlen;
        best_lo_q  <= prev_q;
      end
      if (in_tab) begin
        prev_q <= e.hi;
        if (hit) begin
          match_q <= 1'b1;
          mpos_q  <= idx_q;
          mlen_q  <= elen;
          mhi_q   <= e.hi;
        end
        if (func_q == cha_pkg::FnCompact) begin
          ent_q[idx_q[PW-1:0]].lo <= top_q;
          ent_q[idx_q[PW-1:0]].hi <= top_q + elen;
          top_q <= top_q + elen;
        end
      end
    end
    if (cmd_i.commit) begin
      st_q <= res_st;
      sa_q <= do_ins ? best_lo_q : '0;
      ea_q <= do_ins ? best_lo_q + size_q : (do_rem ? mhi_q : '0);
      for (int i = 0; i < NB; i++) begin
        if (do_ins) begin
          if (CW'(i) == best_pos_q) begin
            ent_q[i].id <= id_q;
            ent_q[i].lo <= best_lo_q;
            ent_q[i].hi <= best_lo_q + size_q;
          end else if (CW'(i) > best_pos_q) begin
            ent_q[i] <= ent_q[(i == 0) ? 0 : i - 1];
          end
        end else if (do_rem && CW'(i) >= mpos_q && i < NB - 1) begin
          ent_q[i] <= ent_q[(i == NB - 1) ? i : i + 1];
        end
      end
    end
  end

  assign status_o         = st_q;
  assign start_address_o  = sa_q;
  assign end_address_o    = ea_q;
  assign free_remaining_o = free_q;

endmodule

FILE: rtl/contiguous_hole_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_hole_allocator
// First-fit / best-fit allocator over an address-ordered table of 16 blocks.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries func, block id and size;
// output channel (out_valid_o/out_ready_i) returns status, start and end
// address and the free space left. One result per input transfer.
// Each operation scans the table (at most 16 entries) one entry per cycle
// through a single read port, then commits and registers the result.
// One operation is in flight at a time; a new input is taken while the
// previous result still waits in the output register.
// If the receiver stalls, the finished operation holds before commit until
// the output register frees up.
// Reset empties the table, sets memory size to 1024, free space to 1024
// and first-fit mode. Writing memory_size (index 0) empties the table;
// writing fit_mode (index 1) keeps it. Write configuration only when idle.
// ----------------------------------------------------------------------------
module contiguous_hole_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cha_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cha_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [cha_pkg::IdW-1:0]       block_id_i,
  input  logic [cha_pkg::AddrW-1:0]     block_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [cha_pkg::AddrW-1:0]     start_address_o,
  output logic [cha_pkg::AddrW-1:0]     end_address_o,
  output logic [cha_pkg::AddrW-1:0]     free_remaining_o
);

  cha_pkg::cmd_t  cmd;
  cha_pkg::stat_t stat;

  cha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cha_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .func_i           (func_i),
    .block_id_i       (block_id_i),
    .block_size_i     (block_size_i),
    .status_o         (status_o),
    .start_address_o  (start_address_o),
    .end_address_o    (end_address_o),
    .free_remaining_o (free_remaining_o)
  );

endmodule

FILE: rtl/cha_checker.sv
// ----------------------------------------------------------------------------
// cha_checker
// Port-level checks for the contiguous hole allocator.
// ----------------------------------------------------------------------------
module cha_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [2:0]                status_o,
  input logic [cha_pkg::AddrW-1:0] start_address_o,
  input logic [cha_pkg::AddrW-1:0] end_address_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(start_address_o) && $stable(end_address_o))
    else $error("stalled result changed");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= cha_pkg::StFull)
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != cha_pkg::StOk |->
      start_address_o == '0 && end_address_o == '0)
    else $error("failed transfer carries addresses");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == cha_pkg::StOk |-> end_address_o >= start_address_o)
    else $error("block end below start");

endmodule

bind contiguous_hole_allocator cha_checker u_cha_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .start_address_o (start_address_o),
  .end_address_o   (end_address_o)
);
